### rtl/hid_keyboard_report_tracker_macros.svh
// ----------------------------------------------------------------------------
// hid_keyboard_report_tracker_macros.svh
// Assertion macros shared by the report tracker modules.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_TRACKER_MACROS_SVH
`define HID_KEYBOARD_REPORT_TRACKER_MACROS_SVH

// implication checked in the next cycle, disabled in reset
`define HKRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// same-cycle implication, disabled in reset
`define HKRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/hkrt_pkg.sv
// ----------------------------------------------------------------------------
// hkrt_pkg
// Constants and controller/datapath interface types of the report tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package hkrt_pkg;

  localparam int KEY_SLOT_COUNT = 10;
  localparam int OUT_SLOTS      = 10;
  localparam int OUT_W          = 8 * (OUT_SLOTS + 1);

  localparam logic [1:0] ACT_DOWN  = 2'd0;
  localparam logic [1:0] ACT_UP    = 2'd1;
  localparam logic [1:0] ACT_PRESS = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // modifier codes 0xE0..0xE7 share these upper bits
  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  typedef struct packed {
    logic capture;
    logic search;
    logic apply;
    logic op_up;
    logic load_out;
    logic last;
  } hkrt_cmd_t;

  typedef struct packed {
    logic out_free;
  } hkrt_stat_t;

endpackage

`default_nettype wire

### rtl/hkrt_datapath.sv
// ----------------------------------------------------------------------------
// hkrt_datapath
// Report state, slot search, slot update and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrt_datapath
  import hkrt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hkrt_cmd_t        cmd,
  output hkrt_stat_t            stat,
  input  wire logic [7:0]       in_code,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [OUT_W-1:0]      out_data,
  output logic                  out_last
);

  logic [7:0]                modifier_r, modifier_nxt;
  logic [7:0]                slots_r   [KEY_SLOT_COUNT];
  logic [7:0]                slots_nxt [KEY_SLOT_COUNT];
  logic [7:0]                code_r;
  logic [KEY_SLOT_COUNT-1:0] match_ge_r, first_empty_r;
  logic [KEY_SLOT_COUNT-1:0] match_ge, first_empty;
  logic                      any_match_r, any_empty_r;
  logic                      out_valid_r;
  logic [OUT_W-1:0]          out_data_r;
  logic                      out_last_r;
  logic [OUT_W-1:0]          report;
  logic                      is_mod;

  assign is_mod = (code_r[7:3] == MOD_PREFIX);

  // match_ge: a match at or below this slot; first_empty: lowest empty slot
  always_comb begin
    logic [KEY_SLOT_COUNT-1:0] match, empty;
    logic                      acc_m, acc_e;
    for (int j = 0; j < KEY_SLOT_COUNT; j++) begin
      match[j] = (slots_r[j] == code_r);
      empty[j] = (slots_r[j] == 8'd0);
    end
    for (int j = 0; j < KEY_SLOT_COUNT; j++) begin
      acc_m = 1'b0;
      acc_e = 1'b0;
      for (int k = 0; k < KEY_SLOT_COUNT; k++) begin
        if (k <= j) acc_m = acc_m | match[k];
        if (k < j)  acc_e = acc_e | empty[k];
      end
      match_ge[j]    = acc_m;
      first_empty[j] = empty[j] & ~acc_e;
    end
  end

  always_comb begin
    modifier_nxt = modifier_r;
    for (int j = 0; j < KEY_SLOT_COUNT; j++) slots_nxt[j] = slots_r[j];
    if (cmd.apply) begin
      if (is_mod) begin
        if (cmd.op_up) modifier_nxt[code_r[2:0]] = 1'b0;
        else           modifier_nxt[code_r[2:0]] = 1'b1;
      end else if (code_r != 8'd0) begin
        if (!cmd.op_up) begin
          if (!any_match_r) begin
            if (any_empty_r) begin
              for (int j = 0; j < KEY_SLOT_COUNT; j++)
                if (first_empty_r[j]) slots_nxt[j] = code_r;
            end else begin
              for (int j = 0; j < KEY_SLOT_COUNT - 1; j++) slots_nxt[j] = slots_r[j+1];
              slots_nxt[KEY_SLOT_COUNT-1] = code_r;
            end
          end
        end else if (any_match_r) begin
          for (int j = 0; j < KEY_SLOT_COUNT - 1; j++)
            if (match_ge_r[j]) slots_nxt[j] = slots_r[j+1];
          slots_nxt[KEY_SLOT_COUNT-1] = 8'd0;
        end
      end
    end
  end

  assign report[7:0] = modifier_r;
  for (genvar g = 0; g < OUT_SLOTS; g++) begin : g_rep
    if (g < KEY_SLOT_COUNT) begin : g_on
      assign report[8*g+15 : 8*g+8] = slots_r[g];
    end else begin : g_off
      assign report[8*g+15 : 8*g+8] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modifier_r  <= 8'd0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < KEY_SLOT_COUNT; j++) slots_r[j] <= 8'd0;
    end else begin
      modifier_r <= modifier_nxt;
      for (int j = 0; j < KEY_SLOT_COUNT; j++) slots_r[j] <= slots_nxt[j];
      if (cmd.load_out)     out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) code_r <= in_code;
    if (cmd.search) begin
      match_ge_r    <= match_ge;
      first_empty_r <= first_empty;
      any_match_r   <= match_ge[KEY_SLOT_COUNT-1];
      any_empty_r   <= |first_empty;
    end
    if (cmd.load_out) begin
      out_data_r <= report;
      out_last_r <= cmd.last;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_last      = out_last_r;

`include "hid_keyboard_report_tracker_macros.svh"

  `HKRT_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid_r, "output not valid after load")
  `HKRT_ASSERT_NOW(a_load_when_free, cmd.load_out, stat.out_free, "output overwritten")

endmodule

`default_nettype wire

### rtl/hkrt_ctrl.sv
// ----------------------------------------------------------------------------
// hkrt_ctrl
// Sequencer: accept, search, apply, send; second pass for press-release.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrt_ctrl
  import hkrt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_action,
  output hkrt_cmd_t       cmd,
  input  wire hkrt_stat_t stat
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SRCH  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_SEND  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   up_r, up_nxt;
  logic   two_r, two_nxt;
  logic   acc;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    up_nxt       = up_r;
    two_nxt      = two_r;
    cmd          = '0;
    cmd.op_up    = up_r;
    cmd.last     = !two_r || up_r;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = acc;
        if (acc) begin
          up_nxt  = (in_action == ACT_UP);
          two_nxt = (in_action == ACT_PRESS);
          if (in_action != ACT_NONE) state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        cmd.search = 1'b1;
        state_nxt  = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (two_r && !up_r) begin
            up_nxt    = 1'b1;
            state_nxt = ST_SRCH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      up_r    <= 1'b0;
      two_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      up_r    <= up_nxt;
      two_r   <= two_nxt;
    end
  end

`include "hid_keyboard_report_tracker_macros.svh"

  `HKRT_ASSERT_NEXT(a_none_drops, acc && (in_action == ACT_NONE), state_r == ST_IDLE, "ignored action started work")
  `HKRT_ASSERT_NEXT(a_item_starts, acc && (in_action != ACT_NONE), state_r == ST_SRCH, "item not searched")
  `HKRT_ASSERT_NEXT(a_press_second, cmd.load_out && two_r && !up_r, (state_r == ST_SRCH) && up_r, "release half skipped")

endmodule

`default_nettype wire

### rtl/hid_keyboard_report_tracker.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_tracker
// Keyboard report tracker: modifier byte plus ordered key slots.
// ----------------------------------------------------------------------------
// Input channel in_*: one key event per item, action in tuser, code in tdata.
// Output channel out_*: one report per item; tlast marks the final report
// of an event. Down and up give one report, press-release gives two, the
// unused action gives none.
// After an event is accepted, the sequencer steps through search, update
// and output load before the report is offered; it handles one event at
// a time, and a press-release runs these steps twice.
// The output register holds a report while out_tready is low; the block
// waits before loading the next one and keeps in_tready low while it waits.
// Reset clears all slots, the modifier byte and the output valid flag;
// the first event may be sent in the cycle after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_keyboard_report_tracker
  import hkrt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] key_code
  input  wire logic [1:0]       in_tuser,   // [1:0] action
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // [7:0] modifier_bits, then slot0..slot9
  output logic                  out_tlast   // last_report
);

  hkrt_cmd_t  cmd;
  hkrt_stat_t stat;

  hkrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

  hkrt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_code   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire
